@@ rtl/bmhpq_pkg.sv @@
// ----------------------------------------------------------------------------
// bmhpq_pkg
// Shared codes and field widths for the binary max-heap priority queue.
// ----------------------------------------------------------------------------
package bmhpq_pkg;

  localparam int VALUE_W  = 32;
  localparam int STATUS_W = 2;
  localparam int ENTRY_W  = 9;

  localparam logic KIND_INSERT  = 1'b0;
  localparam logic KIND_EXTRACT = 1'b1;

  localparam logic [STATUS_W-1:0] STATUS_OK        = 2'd0;
  localparam logic [STATUS_W-1:0] STATUS_UNDERFLOW = 2'd1;
  localparam logic [STATUS_W-1:0] STATUS_OVERFLOW  = 2'd2;

endpackage
// ----------------------------------------------------------------------------

@@ rtl/binary_max_heap_priority_queue_top.sv @@
// ----------------------------------------------------------------------------
// binary_max_heap_priority_queue_top
// Priority queue held as a one-based binary max heap in a synchronous RAM.
//
// A request is taken when start is high and busy is low. Every request gives
// exactly one result, shown for one cycle with done high; the receiver cannot
// stall it. An insert or an extract walks the heap one level per pass through
// a RAM read state and then a compare-and-write state, and the sift loop goes
// through the single write port. Inserting into a full heap or extracting from
// an empty one returns in the next cycle with an error status and leaves the
// heap as it was. The RAM needs no clearing after reset.
// ----------------------------------------------------------------------------
module binary_max_heap_priority_queue_top #(
  parameter int CAPACITY   = 256,
  parameter int DATA_WIDTH = 32
) (
  input  logic                                clk,
  input  logic                                rst,
  input  logic                                start,
  output logic                                busy,
  input  logic                                kind,
  input  logic signed [bmhpq_pkg::VALUE_W-1:0] value,
  output logic                                done,
  output logic signed [bmhpq_pkg::VALUE_W-1:0] result_value,
  output logic [bmhpq_pkg::STATUS_W-1:0]      status,
  output logic [bmhpq_pkg::ENTRY_W-1:0]       entry_count
);

  import bmhpq_pkg::*;

  localparam int CW = $clog2(CAPACITY + 1);

  typedef enum logic [2:0] {
    S_IDLE,
    S_EXT,
    S_INS_RD,
    S_INS_CMP,
    S_DN_RD,
    S_DN_CMP
  } state_t;

  function automatic logic gt(input logic [DATA_WIDTH-1:0] a,
                              input logic [DATA_WIDTH-1:0] b);
    return $signed(a) > $signed(b);
  endfunction

  state_t                state;
  logic [CW-1:0]         count;
  logic [CW-1:0]         pos;
  logic [DATA_WIDTH-1:0] item;

  // heap RAM, slot 0 unused
  logic [DATA_WIDTH-1:0] mem [0:CAPACITY];
  logic                  wr_en;
  logic [CW-1:0]         wr_addr;
  logic [DATA_WIDTH-1:0] wr_data;
  logic [CW-1:0]         rd_addr_a;
  logic [CW-1:0]         rd_addr_b;
  logic [DATA_WIDTH-1:0] rd_data_a;
  logic [DATA_WIDTH-1:0] rd_data_b;

  logic [CW:0]           left_idx;
  logic [CW:0]           right_idx;
  logic                  left_ok;
  logic                  right_ok;
  logic [CW-1:0]         parent_idx;
  logic                  up_move;
  logic                  l_gt;
  logic                  r_gt;
  logic                  dn_move;
  logic [DATA_WIDTH-1:0] child_val;
  logic [CW-1:0]         child_idx;
  logic [DATA_WIDTH-1:0] in_val;

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
    rd_data_a <= mem[rd_addr_a];
    rd_data_b <= mem[rd_addr_b];
  end

  assign in_val     = DATA_WIDTH'($unsigned(value));
  assign left_idx   = {pos, 1'b0};
  assign right_idx  = left_idx + 1'b1;
  assign left_ok    = left_idx <= {1'b0, count};
  assign right_ok   = right_idx <= {1'b0, count};
  assign parent_idx = pos >> 1;
  assign up_move    = gt(item, rd_data_a);
  assign l_gt       = gt(rd_data_a, item);
  assign r_gt       = right_ok && gt(rd_data_b, l_gt ? rd_data_a : item);
  assign dn_move    = l_gt || r_gt;
  assign child_val  = r_gt ? rd_data_b : rd_data_a;
  assign child_idx  = r_gt ? right_idx[CW-1:0] : left_idx[CW-1:0];

  always_comb begin
    wr_en     = 1'b0;
    wr_addr   = pos;
    wr_data   = item;
    rd_addr_a = CW'(1);
    rd_addr_b = count;
    unique case (state)
      S_INS_RD: begin
        if (pos == CW'(1)) begin
          wr_en = 1'b1;
        end else begin
          rd_addr_a = parent_idx;
        end
      end
      S_INS_CMP: begin
        wr_en   = 1'b1;
        wr_data = up_move ? rd_data_a : item;
      end
      S_DN_RD: begin
        if (!left_ok) begin
          wr_en = 1'b1;
        end else begin
          rd_addr_a = left_idx[CW-1:0];
          rd_addr_b = right_ok ? right_idx[CW-1:0] : left_idx[CW-1:0];
        end
      end
      S_DN_CMP: begin
        wr_en   = 1'b1;
        wr_data = dn_move ? child_val : item;
      end
      default: begin
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
      busy  <= 1'b0;
      done  <= 1'b0;
      count <= '0;
    end else begin
      done <= 1'b0;
      unique case (state)
        S_IDLE: begin
          if (start) begin
            if (kind == KIND_INSERT) begin
              if (count == CW'(CAPACITY)) begin
                done         <= 1'b1;
                result_value <= '0;
                status       <= STATUS_OVERFLOW;
                entry_count  <= ENTRY_W'(count);
              end else begin
                busy  <= 1'b1;
                count <= count + 1'b1;
                pos   <= count + 1'b1;
                item  <= in_val;
                state <= S_INS_RD;
              end
            end else begin
              if (count == '0) begin
                done         <= 1'b1;
                result_value <= '0;
                status       <= STATUS_UNDERFLOW;
                entry_count  <= ENTRY_W'(count);
              end else begin
                busy  <= 1'b1;
                state <= S_EXT;
              end
            end
          end
        end
        S_EXT: begin
          result_value <= VALUE_W'($signed(rd_data_a));
          item         <= rd_data_b;
          count        <= count - 1'b1;
          pos          <= CW'(1);
          if (count == CW'(1)) begin
            done        <= 1'b1;
            busy        <= 1'b0;
            status      <= STATUS_OK;
            entry_count <= '0;
            state       <= S_IDLE;
          end else begin
            state <= S_DN_RD;
          end
        end
        S_INS_RD: begin
          if (pos == CW'(1)) begin
            done         <= 1'b1;
            busy         <= 1'b0;
            result_value <= VALUE_W'($signed(item));
            status       <= STATUS_OK;
            entry_count  <= ENTRY_W'(count);
            state        <= S_IDLE;
          end else begin
            state <= S_INS_CMP;
          end
        end
        S_INS_CMP: begin
          if (up_move) begin
            pos   <= parent_idx;
            state <= S_INS_RD;
          end else begin
            done         <= 1'b1;
            busy         <= 1'b0;
            result_value <= VALUE_W'($signed(item));
            status       <= STATUS_OK;
            entry_count  <= ENTRY_W'(count);
            state        <= S_IDLE;
          end
        end
        S_DN_RD: begin
          if (!left_ok) begin
            done        <= 1'b1;
            busy        <= 1'b0;
            status      <= STATUS_OK;
            entry_count <= ENTRY_W'(count);
            state       <= S_IDLE;
          end else begin
            state <= S_DN_CMP;
          end
        end
        S_DN_CMP: begin
          if (dn_move) begin
            pos   <= child_idx;
            state <= S_DN_RD;
          end else begin
            done        <= 1'b1;
            busy        <= 1'b0;
            status      <= STATUS_OK;
            entry_count <= ENTRY_W'(count);
            state       <= S_IDLE;
          end
        end
        default: begin
          state <= S_IDLE;
          busy  <= 1'b0;
        end
      endcase
    end
  end

endmodule
// ----------------------------------------------------------------------------

@@ verif/binary_max_heap_priority_queue_top_tb.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// binary_max_heap_priority_queue_top_tb
// Self-checking bench for the max-heap priority queue. A queued driver issues
// insert and extract requests in random bursts. Runs include extreme and tied
// values, a fill past capacity and a drain past empty. A scoreboard heap
// predicts every result, and the monitor checks each done strobe in order.
// ----------------------------------------------------------------------------
module binary_max_heap_priority_queue_top_tb;
  import bmhpq_pkg::*;

  localparam int CAPACITY   = 256;
  localparam int DATA_WIDTH = 32;
  localparam int NUM_REQS   = 1300;

  typedef struct packed {
    logic                       kind;
    logic signed [VALUE_W-1:0]  value;
  } heap_req_t;

  typedef struct packed {
    logic signed [VALUE_W-1:0]  value;
    logic [STATUS_W-1:0]        status;
    logic [ENTRY_W-1:0]         count;
  } heap_answer_t;

  logic                       clk;
  logic                       rst;
  logic                       start;
  logic                       busy;
  logic                       kind;
  logic signed [VALUE_W-1:0]  value;
  logic                       done;
  logic signed [VALUE_W-1:0]  result_value;
  logic [STATUS_W-1:0]        status;
  logic [ENTRY_W-1:0]         entry_count;

  heap_req_t    req_pending[$];
  heap_answer_t answer_q[$];

  logic signed [VALUE_W-1:0] heap_mem [1:CAPACITY];
  int heap_depth;
  int gen_depth;

  logic req_taken;
  int   burst_left;
  int   gap_left;

  int err_count;
  int n_insert, n_extract, n_underflow, n_overflow, peak_depth;

  binary_max_heap_priority_queue_top #(
    .CAPACITY   (CAPACITY),
    .DATA_WIDTH (DATA_WIDTH)
  ) DUT (
    .clk          (clk),
    .rst          (rst),
    .start        (start),
    .busy         (busy),
    .kind         (kind),
    .value        (value),
    .done         (done),
    .result_value (result_value),
    .status       (status),
    .entry_count  (entry_count)
  );

  initial begin
    clk = 1'b0;
    forever #1 clk = ~clk;
  end

  function automatic heap_answer_t heap_apply(input logic k,
                                              input logic signed [VALUE_W-1:0] v);
    heap_answer_t              a;
    int                        pos;
    int                        l;
    int                        r;
    int                        best;
    logic                      settled;
    logic signed [VALUE_W-1:0] t;
    a.value  = '0;
    a.status = STATUS_OK;
    if (k == KIND_INSERT) begin
      if (heap_depth >= CAPACITY) begin
        a.status = STATUS_OVERFLOW;
      end else begin
        heap_depth++;
        pos = heap_depth;
        heap_mem[pos] = v;
        while (pos > 1 && heap_mem[pos] > heap_mem[pos / 2]) begin
          t = heap_mem[pos];
          heap_mem[pos] = heap_mem[pos / 2];
          heap_mem[pos / 2] = t;
          pos = pos / 2;
        end
        a.value = v;
      end
    end else begin
      if (heap_depth == 0) begin
        a.status = STATUS_UNDERFLOW;
      end else begin
        a.value = heap_mem[1];
        heap_mem[1] = heap_mem[heap_depth];
        heap_depth--;
        pos = 1;
        settled = 1'b0;
        while (!settled) begin
          l = 2 * pos;
          r = l + 1;
          best = pos;
          if (l <= heap_depth && heap_mem[l] > heap_mem[best]) best = l;
          if (r <= heap_depth && heap_mem[r] > heap_mem[best]) best = r;
          if (best == pos) begin
            settled = 1'b1;
          end else begin
            t = heap_mem[pos];
            heap_mem[pos] = heap_mem[best];
            heap_mem[best] = t;
            pos = best;
          end
        end
      end
    end
    a.count = ENTRY_W'(heap_depth);
    return a;
  endfunction

  task automatic report_mismatch(input string field, input longint got,
                                 input longint want);
    $display("[%0t] mismatch on %s: got %0d, expected %0d", $time, field, got, want);
    err_count++;
  endtask

  task automatic push_req(input logic k, input logic signed [VALUE_W-1:0] v);
    heap_req_t r;
    r.kind  = k;
    r.value = v;
    req_pending.push_back(r);
    if (k == KIND_INSERT && gen_depth < CAPACITY) gen_depth++;
    if (k == KIND_EXTRACT && gen_depth > 0) gen_depth--;
  endtask

  // mix of full-range, small tie-prone and extreme values
  function automatic logic signed [VALUE_W-1:0] pick_value();
    int sel;
    sel = $urandom_range(0, 7);
    if (sel < 4) return $signed($urandom);
    if (sel < 6) return $signed($urandom_range(0, 6)) - 3;
    case ($urandom_range(0, 3))
      0: return 32'sh7FFF_FFFF;
      1: return 32'sh8000_0000;
      2: return 32'sh7FFF_FFFE;
      default: return 32'sh8000_0001;
    endcase
  endfunction

  // driver
  always @(negedge clk) begin
    if (rst) begin
      start <= 1'b0;
    end else if (!start || req_taken) begin
      if (gap_left > 0) begin
        start <= 1'b0;
        gap_left--;
      end else if (req_pending.size() > 0) begin
        start <= 1'b1;
        kind  <= req_pending[0].kind;
        value <= req_pending[0].value;
        void'(req_pending.pop_front());
        burst_left--;
        if (burst_left <= 0) begin
          burst_left = $urandom_range(1, 30);
          gap_left   = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 25);
        end
      end else begin
        start <= 1'b0;
      end
    end
  end

  // monitor and scoreboard
  always @(posedge clk) begin
    heap_answer_t want;
    if (rst) begin
      req_taken <= 1'b0;
    end else begin
      if (done) begin
        if (answer_q.size() == 0) begin
          $display("[%0t] result with no request outstanding", $time);
          err_count++;
        end else begin
          want = answer_q.pop_front();
          if (result_value !== want.value)
            report_mismatch("result_value", result_value, want.value);
          if (status !== want.status)
            report_mismatch("status", status, want.status);
          if (entry_count !== want.count)
            report_mismatch("entry_count", entry_count, want.count);
          case (want.status)
            STATUS_UNDERFLOW: n_underflow++;
            STATUS_OVERFLOW:  n_overflow++;
            default: begin
              if (want.count > peak_depth) peak_depth = want.count;
            end
          endcase
        end
      end
      req_taken <= start && !busy;
      if (start && !busy) begin
        if (kind == KIND_INSERT) n_insert++;
        else n_extract++;
        answer_q.push_back(heap_apply(kind, value));
      end
    end
  end

  initial begin
    int total;
    rst        = 1'b1;
    start      = 1'b0;
    kind       = KIND_INSERT;
    value      = '0;
    req_taken  = 1'b0;
    heap_depth = 0;
    gen_depth  = 0;
    err_count  = 0;
    n_insert   = 0;
    n_extract  = 0;
    n_underflow = 0;
    n_overflow = 0;
    peak_depth = 0;
    burst_left = $urandom_range(1, 30);
    gap_left   = 0;

    // directed: empty extract, extremes, ties, drain past empty
    push_req(KIND_EXTRACT, 32'sh1234_5678);
    push_req(KIND_INSERT, 32'sh7FFF_FFFF);
    push_req(KIND_INSERT, 32'sh8000_0000);
    push_req(KIND_INSERT, 32'sh0000_0000);
    push_req(KIND_INSERT, -32'sd1);
    push_req(KIND_INSERT, 32'sd1);
    push_req(KIND_INSERT, 32'sd5);
    push_req(KIND_INSERT, 32'sd5);
    push_req(KIND_INSERT, 32'sd5);
    push_req(KIND_INSERT, 32'sh7FFF_FFFF);
    push_req(KIND_INSERT, 32'sh8000_0000);
    for (int i = 0; i < 11; i++) push_req(KIND_EXTRACT, $signed($urandom));

    // grow with a mostly-insert mix
    for (int i = 0; i < 400; i++)
      push_req(($urandom_range(0, 9) < 6) ? KIND_INSERT : KIND_EXTRACT, pick_value());
    // fill to capacity, then overflow
    while (gen_depth < CAPACITY) push_req(KIND_INSERT, pick_value());
    for (int i = 0; i < 4; i++) push_req(KIND_INSERT, pick_value());
    // drain past empty with a few inserts mixed in
    while (gen_depth > 0)
      push_req(($urandom_range(0, 9) < 8) ? KIND_EXTRACT : KIND_INSERT, pick_value());
    for (int i = 0; i < 3; i++) push_req(KIND_EXTRACT, pick_value());
    total = req_pending.size();
    while (total < NUM_REQS) begin
      push_req($urandom_range(0, 1) ? KIND_EXTRACT : KIND_INSERT, pick_value());
      total++;
    end

    repeat (2) @(posedge clk);
    @(negedge clk);
    rst = 1'b0;

    while (req_pending.size() > 0 || start || answer_q.size() > 0) @(posedge clk);
    repeat (30) @(posedge clk);

    $display("Ran %0d requests: %0d inserts, %0d extracts.", n_insert + n_extract,
             n_insert, n_extract);
    $display("Underflows %0d, overflows %0d, peak heap depth %0d.", n_underflow,
             n_overflow, peak_depth);
    if (err_count == 0) begin
      $display("CHECK OK");
    end else begin
      $display("CHECK FAILED");
    end
    $finish;
  end

  initial begin
    #1000000;
    $display("Timed out with %0d requests queued, %0d results outstanding.",
             req_pending.size(), answer_q.size());
    $display("CHECK FAILED");
    $finish;
  end

endmodule

@@ files.f @@
rtl/bmhpq_pkg.sv
rtl/binary_max_heap_priority_queue_top.sv
verif/binary_max_heap_priority_queue_top_tb.sv
